// ----- rtl/core/avad_pkg.sv -----
// Shared types, constants and sector tables for the vector angle pipeline.
`default_nettype none

package avad_pkg;

    localparam int COORD_WIDTH_DEF     = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 8;
    localparam int ANGLE_INT_BITS      = 9;
    localparam int TOL_WIDTH           = 16;
    localparam int COEF_WIDTH          = 17;
    localparam int OFFS_WIDTH          = 9;
    localparam int SEC_WIDTH           = 3;
    localparam int RATIO_INT_BITS      = 6;

    localparam int APB_ADDR_WIDTH = 3;
    localparam int APB_DATA_WIDTH = 32;
    localparam int REG_IDX_WIDTH  = APB_ADDR_WIDTH - 2;

    localparam logic [REG_IDX_WIDTH-1:0] REG_ZERO_TOL = '0;

    localparam int UNIT_Q15       = 32768;
    localparam int HALF_SQRT2_Q15 = 23170;

    localparam int DEG_0   = 0;
    localparam int DEG_45  = 45;
    localparam int DEG_90  = 90;
    localparam int DEG_135 = 135;
    localparam int DEG_180 = 180;

    localparam int RATIO_DEG = DEG_45;

    localparam logic MODE_FOUR  = 1'b0;
    localparam logic MODE_EIGHT = 1'b1;

    typedef logic [SEC_WIDTH-1:0] t_sec;

    // four-sector mode: quadrants centered on the axes
    localparam t_sec QUAD_E = 3'd0;
    localparam t_sec QUAD_N = 3'd1;
    localparam t_sec QUAD_S = 3'd2;
    localparam t_sec QUAD_W = 3'd3;

    // eight-sector mode: octant k starts at k*45 degrees
    localparam t_sec OCT_E  = 3'd0;
    localparam t_sec OCT_NE = 3'd1;
    localparam t_sec OCT_N  = 3'd2;
    localparam t_sec OCT_NW = 3'd3;
    localparam t_sec OCT_W  = 3'd4;
    localparam t_sec OCT_SW = 3'd5;
    localparam t_sec OCT_S  = 3'd6;
    localparam t_sec OCT_SE = 3'd7;

    localparam logic signed [COEF_WIDTH-1:0] C_UNIT = COEF_WIDTH'(UNIT_Q15);
    localparam logic signed [COEF_WIDTH-1:0] C_HALF = COEF_WIDTH'(HALF_SQRT2_Q15);
    localparam logic signed [COEF_WIDTH-1:0] C_DIFF = COEF_WIDTH'(UNIT_Q15 - HALF_SQRT2_Q15);
    localparam logic signed [COEF_WIDTH-1:0] C_ZERO = '0;

    // numerator = x*ay - y*ax, denominator = x*dy - y*dx
    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] ax;
        logic signed [COEF_WIDTH-1:0] ay;
        logic signed [COEF_WIDTH-1:0] dx;
        logic signed [COEF_WIDTH-1:0] dy;
    } t_coef;

    typedef struct packed {
        logic zero;
        logic mode;
        t_sec sec;
        logic neg;
        logic dz;
    } t_side;

    function automatic t_coef sector_coef(input logic mode, input t_sec sec);
        t_coef c;
        c = '0;
        if (mode == MODE_FOUR) begin
            // scaled by the unit vector; the ratio does not change
            case (sec)
                QUAD_E, QUAD_W: begin
                    c.ax = -C_UNIT; c.ay = C_ZERO;   // n = y
                    c.dx = C_ZERO;  c.dy = C_UNIT;   // d = x
                end
                default: begin
                    c.ax = C_ZERO;  c.ay = C_UNIT;   // n = x
                    c.dx = -C_UNIT; c.dy = C_ZERO;   // d = y
                end
            endcase
        end else begin
            case (sec)
                OCT_E:  begin c.ax = C_UNIT;  c.ay = C_ZERO;  c.dx = C_DIFF;  c.dy = -C_HALF; end
                OCT_NE: begin c.ax = C_HALF;  c.ay = C_HALF;  c.dx = C_HALF;  c.dy = -C_DIFF; end
                OCT_N:  begin c.ax = C_ZERO;  c.ay = C_UNIT;  c.dx = C_HALF;  c.dy = C_DIFF;  end
                OCT_NW: begin c.ax = -C_HALF; c.ay = C_HALF;  c.dx = C_DIFF;  c.dy = C_HALF;  end
                OCT_W:  begin c.ax = -C_UNIT; c.ay = C_ZERO;  c.dx = -C_DIFF; c.dy = C_HALF;  end
                OCT_SW: begin c.ax = -C_HALF; c.ay = -C_HALF; c.dx = -C_HALF; c.dy = C_DIFF;  end
                OCT_S:  begin c.ax = C_ZERO;  c.ay = -C_UNIT; c.dx = -C_HALF; c.dy = -C_DIFF; end
                default: begin
                    c.ax = C_HALF; c.ay = -C_HALF; c.dx = -C_DIFF; c.dy = -C_HALF;
                end
            endcase
        end
        return c;
    endfunction

    // sector base angle in whole degrees (quadrant centre or octant start); west quadrant gets its sign later
    function automatic logic signed [OFFS_WIDTH-1:0] sector_offset(input logic mode,
                                                                   input t_sec sec);
        logic signed [OFFS_WIDTH-1:0] off;
        off = '0;
        if (mode == MODE_FOUR) begin
            case (sec)
                QUAD_E:  off = OFFS_WIDTH'(DEG_0);
                QUAD_N:  off = OFFS_WIDTH'(DEG_90);
                QUAD_S:  off = -OFFS_WIDTH'(DEG_90);
                default: off = OFFS_WIDTH'(DEG_180);
            endcase
        end else begin
            case (sec)
                OCT_E:   off = OFFS_WIDTH'(DEG_0);
                OCT_NE:  off = OFFS_WIDTH'(DEG_45);
                OCT_N:   off = OFFS_WIDTH'(DEG_90);
                OCT_NW:  off = OFFS_WIDTH'(DEG_135);
                OCT_W:   off = -OFFS_WIDTH'(DEG_180);
                OCT_SW:  off = -OFFS_WIDTH'(DEG_135);
                OCT_S:   off = -OFFS_WIDTH'(DEG_90);
                default: off = -OFFS_WIDTH'(DEG_45);
            endcase
        end
        return off;
    endfunction

    // quadrants above and below the axis subtract the ratio
    function automatic logic sector_sub(input logic mode, input t_sec sec);
        return (mode == MODE_FOUR) && ((sec == QUAD_N) || (sec == QUAD_S));
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/avad_in_if.sv -----
// Input channel: vector components and mode select.
`default_nettype none

interface avad_in_if #(
    parameter int COORD_WIDTH = avad_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic signed [COORD_WIDTH-1:0] x_coord;
    logic signed [COORD_WIDTH-1:0] y_coord;

    modport source (output valid, mode, x_coord, y_coord, input ready);
    modport sink   (input valid, mode, x_coord, y_coord, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/avad_out_if.sv -----
// Output channel: angle in fixed-point degrees and zero-vector flag.
`default_nettype none

interface avad_out_if #(
    parameter int ANGLE_FRAC_BITS = avad_pkg::ANGLE_FRAC_BITS_DEF
);
    logic                                                      valid;
    logic                                                      ready;
    logic signed [ANGLE_FRAC_BITS+avad_pkg::ANGLE_INT_BITS-1:0] angle_q8;
    logic                                                      zero_vector;

    modport source (output valid, angle_q8, zero_vector, input ready);
    modport sink   (input valid, angle_q8, zero_vector, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/approx_vector_angle_degrees.sv -----
// Vector angle approximation: fully pipelined, one transaction per cycle while the output is not stalled.
//
// i_req carries (mode, x_coord, y_coord); o_rsp returns angle_q8 in degrees
// with ANGLE_FRAC_BITS fraction bits on [-180,180] and a zero_vector flag.
// Both are valid/ready channels; a transaction moves when valid and ready
// are high at a rising edge. The APB port holds zero_tolerance at offset 0.
//
// Pipeline: six stages for sector select, cross products, numerator and
// denominator, magnitudes, clamp and the x45 scale, one restoring-divider
// stage per quotient bit (6 + ANGLE_FRAC_BITS), then sign and offset and
// the output register. Throughput is one transaction per cycle while the
// receiver accepts; valid bits travel with the data.
//
// Synchronous reset empties the pipeline and clears zero_tolerance. When
// the receiver stalls, stages fill up behind the output register; i_req
// stays ready as long as any stage holds a bubble.
`default_nettype none

module approx_vector_angle_degrees #(
    parameter int COORD_WIDTH     = avad_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = avad_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    avad_in_if.sink                                  i_req,
    avad_out_if.source                               o_rsp,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [avad_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  wire logic [avad_pkg::APB_DATA_WIDTH-1:0] pwdata,
    output logic      [avad_pkg::APB_DATA_WIDTH-1:0] prdata,
    output logic                                     pready
);

    localparam int CW  = COORD_WIDTH;
    localparam int CW1 = CW + 1;
    localparam int TW  = avad_pkg::TOL_WIDTH;
    localparam int MW  = (CW > TW) ? CW : TW;
    localparam int PW  = CW + avad_pkg::COEF_WIDTH;
    localparam int SW  = PW + 1;
    localparam int NW  = SW + avad_pkg::RATIO_INT_BITS;
    localparam int RB  = avad_pkg::RATIO_INT_BITS;
    localparam int F   = ANGLE_FRAC_BITS;
    localparam int QB  = RB + F;
    localparam int AW  = F + avad_pkg::ANGLE_INT_BITS;

    localparam int ST_A  = 0;
    localparam int ST_B  = 1;
    localparam int ST_C  = 2;
    localparam int ST_D  = 3;
    localparam int ST_E  = 4;
    localparam int ST_F  = 5;
    localparam int ST_G0 = 6;
    localparam int ST_H  = ST_G0 + QB;
    localparam int ST_O  = ST_H + 1;
    localparam int NS    = ST_O + 1;

    localparam logic [QB-1:0]        QMAX      = QB'(avad_pkg::RATIO_DEG << F);
    localparam logic signed [AW-1:0] HALF_TURN = AW'(avad_pkg::DEG_180 << F);

    // ---------------- configuration ----------------
    logic [TW-1:0]                          r_zero_tol;
    logic [avad_pkg::REG_IDX_WIDTH-1:0]     reg_idx;

    assign reg_idx = paddr[avad_pkg::APB_ADDR_WIDTH-1:2];
    assign pready  = 1'b1;
    assign prdata  = (reg_idx == avad_pkg::REG_ZERO_TOL) ?
                     avad_pkg::APB_DATA_WIDTH'(r_zero_tol) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_tol <= '0;
        end else if (psel && penable && pwrite && pready &&
                     (reg_idx == avad_pkg::REG_ZERO_TOL)) begin
            r_zero_tol <= pwdata[TW-1:0];
        end
    end

    // ---------------- flow control ----------------
    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS-1:0] en;

    always_comb begin
        en[NS-1] = !r_vld[NS-1] || o_rsp.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign n_vld       = {r_vld[NS-2:0], i_req.valid};
    assign i_req.ready = en[ST_A];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    // ---------------- stage A: sector and zero test ----------------
    logic [CW-1:0]        x_u, y_u, mag_x, mag_y;
    logic signed [CW1-1:0] sum_xy;
    logic                 ge_diag, le_diag;
    avad_pkg::t_sec       n_a_sec;
    avad_pkg::t_side      n_a_side;

    avad_pkg::t_side       r_a_side;
    logic signed [CW-1:0]  r_a_x, r_a_y;

    assign x_u     = i_req.x_coord;
    assign y_u     = i_req.y_coord;
    assign mag_x   = x_u[CW-1] ? (~x_u + 1'b1) : x_u;
    assign mag_y   = y_u[CW-1] ? (~y_u + 1'b1) : y_u;
    assign sum_xy  = CW1'(i_req.x_coord) + CW1'(i_req.y_coord);
    assign ge_diag = !sum_xy[CW];                    // y >= -x
    assign le_diag = (i_req.y_coord <= i_req.x_coord);

    always_comb begin
        if (i_req.mode == avad_pkg::MODE_FOUR) begin
            if (ge_diag) begin
                n_a_sec = le_diag ? avad_pkg::QUAD_E : avad_pkg::QUAD_N;
            end else begin
                n_a_sec = le_diag ? avad_pkg::QUAD_S : avad_pkg::QUAD_W;
            end
        end else if (!i_req.y_coord[CW-1]) begin
            if (!i_req.x_coord[CW-1]) begin
                n_a_sec = le_diag ? avad_pkg::OCT_E : avad_pkg::OCT_NE;
            end else begin
                n_a_sec = (ge_diag && (sum_xy != '0)) ? avad_pkg::OCT_N : avad_pkg::OCT_NW;
            end
        end else begin
            if (i_req.x_coord[CW-1]) begin
                n_a_sec = (i_req.y_coord >= i_req.x_coord) ? avad_pkg::OCT_W
                                                           : avad_pkg::OCT_SW;
            end else begin
                n_a_sec = ge_diag ? avad_pkg::OCT_SE : avad_pkg::OCT_S;
            end
        end
    end

    always_comb begin
        n_a_side      = '0;
        n_a_side.mode = i_req.mode;
        n_a_side.sec  = n_a_sec;
        n_a_side.zero = (MW'(mag_x) <= MW'(r_zero_tol)) && (MW'(mag_y) <= MW'(r_zero_tol));
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_A]) begin
            r_a_side <= n_a_side;
            r_a_x    <= i_req.x_coord;
            r_a_y    <= i_req.y_coord;
        end
    end

    // ---------------- stage B: cross products ----------------
    avad_pkg::t_coef       coef;
    avad_pkg::t_side       r_b_side;
    logic signed [PW-1:0]  r_b_pn1, r_b_pn2, r_b_pd1, r_b_pd2;

    assign coef = avad_pkg::sector_coef(r_a_side.mode, r_a_side.sec);

    always_ff @(posedge i_clk) begin
        if (en[ST_B]) begin
            r_b_side <= r_a_side;
            r_b_pn1  <= PW'(r_a_x) * PW'(coef.ay);
            r_b_pn2  <= PW'(r_a_y) * PW'(coef.ax);
            r_b_pd1  <= PW'(r_a_x) * PW'(coef.dy);
            r_b_pd2  <= PW'(r_a_y) * PW'(coef.dx);
        end
    end

    // ---------------- stage C: numerator and denominator ----------------
    avad_pkg::t_side       r_c_side;
    logic signed [SW-1:0]  r_c_num, r_c_den;

    always_ff @(posedge i_clk) begin
        if (en[ST_C]) begin
            r_c_side <= r_b_side;
            r_c_num  <= SW'(r_b_pn1) - SW'(r_b_pn2);
            r_c_den  <= SW'(r_b_pd1) - SW'(r_b_pd2);
        end
    end

    // ---------------- stage D: magnitudes and quotient sign ----------------
    logic [SW-1:0]    c_num_u, c_den_u;
    avad_pkg::t_side  n_d_side;
    avad_pkg::t_side  r_d_side;
    logic [SW-1:0]    r_d_num, r_d_den;

    assign c_num_u = r_c_num;
    assign c_den_u = r_c_den;

    always_comb begin
        n_d_side     = r_c_side;
        n_d_side.neg = r_c_num[SW-1] ^ r_c_den[SW-1];
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_D]) begin
            r_d_side <= n_d_side;
            r_d_num  <= c_num_u[SW-1] ? (~c_num_u + 1'b1) : c_num_u;
            r_d_den  <= c_den_u[SW-1] ? (~c_den_u + 1'b1) : c_den_u;
        end
    end

    // ---------------- stage E: clamp ratio to one ----------------
    avad_pkg::t_side  n_e_side;
    avad_pkg::t_side  r_e_side;
    logic [SW-1:0]    r_e_num, r_e_den;

    always_comb begin
        n_e_side    = r_d_side;
        n_e_side.dz = (r_d_den == '0);
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_E]) begin
            r_e_side <= n_e_side;
            r_e_num  <= (r_d_num > r_d_den) ? r_d_den : r_d_num;
            r_e_den  <= r_d_den;
        end
    end

    // ---------------- stage F: scale by 45 ----------------
    avad_pkg::t_side  r_f_side;
    logic [NW-1:0]    r_f_prod;
    logic [SW-1:0]    r_f_den;

    always_ff @(posedge i_clk) begin
        if (en[ST_F]) begin
            r_f_side <= r_e_side;
            r_f_prod <= NW'(r_e_num) * NW'(avad_pkg::RATIO_DEG);
            r_f_den  <= r_e_den;
        end
    end

    // ---------------- stages G: restoring divider, one bit per stage ----------------
    // dividend is prod * 2^F; prod < 64*den so the top part starts below den
    logic [SW-1:0]    g_rem_in  [QB];
    logic [QB-1:0]    g_feed_in [QB];
    logic [QB-1:0]    g_quo_in  [QB];
    logic [SW-1:0]    g_den_in  [QB];
    avad_pkg::t_side  g_side_in [QB];
    logic [SW:0]      g_trial   [QB];
    logic [SW:0]      g_diff    [QB];
    logic             g_take    [QB];

    logic [SW-1:0]    r_g_rem  [QB];
    logic [QB-1:0]    r_g_feed [QB];
    logic [QB-1:0]    r_g_quo  [QB];
    logic [SW-1:0]    r_g_den  [QB];
    avad_pkg::t_side  r_g_side [QB];

    always_comb begin
        g_rem_in[0]  = r_f_prod[NW-1:RB];
        g_feed_in[0] = {r_f_prod[RB-1:0], {F{1'b0}}};
        g_quo_in[0]  = '0;
        g_den_in[0]  = r_f_den;
        g_side_in[0] = r_f_side;
        for (int k = 1; k < QB; k++) begin
            g_rem_in[k]  = r_g_rem[k-1];
            g_feed_in[k] = r_g_feed[k-1];
            g_quo_in[k]  = r_g_quo[k-1];
            g_den_in[k]  = r_g_den[k-1];
            g_side_in[k] = r_g_side[k-1];
        end
        for (int k = 0; k < QB; k++) begin
            g_trial[k] = {g_rem_in[k], g_feed_in[k][QB-1]};
            g_diff[k]  = g_trial[k] - {1'b0, g_den_in[k]};
            g_take[k]  = (g_trial[k] >= {1'b0, g_den_in[k]});
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QB; k++) begin
            if (en[ST_G0+k]) begin
                r_g_rem[k]  <= g_take[k] ? g_diff[k][SW-1:0] : g_trial[k][SW-1:0];
                r_g_feed[k] <= {g_feed_in[k][QB-2:0], 1'b0};
                r_g_quo[k]  <= {g_quo_in[k][QB-2:0], g_take[k]};
                r_g_den[k]  <= g_den_in[k];
                r_g_side[k] <= g_side_in[k];
            end
        end
    end

    // ---------------- stage H: signed ratio and sector offset ----------------
    avad_pkg::t_side               h_side;
    logic [QB-1:0]                 q_eff;
    logic signed [AW-1:0]          q_s;
    logic signed [AW-1:0]          off_s;
    logic                          flip;
    logic                          west_neg;

    logic                          r_h_zero;
    logic signed [AW-1:0]          r_h_val, r_h_off;

    assign h_side = r_g_side[QB-1];
    assign q_eff  = h_side.dz ? '0 : r_g_quo[QB-1];
    assign q_s    = AW'(q_eff);
    assign flip   = h_side.neg ^ avad_pkg::sector_sub(h_side.mode, h_side.sec);
    assign off_s  = AW'(avad_pkg::sector_offset(h_side.mode, h_side.sec)) <<< F;
    // west quadrant: a positive ratio lands just above -180, else at or below +180
    assign west_neg = (h_side.mode == avad_pkg::MODE_FOUR) &&
                      (h_side.sec == avad_pkg::QUAD_W) &&
                      !h_side.neg && (q_eff != '0);

    always_ff @(posedge i_clk) begin
        if (en[ST_H]) begin
            r_h_zero <= h_side.zero;
            r_h_val  <= flip ? -q_s : q_s;
            r_h_off  <= west_neg ? -off_s : off_s;
        end
    end

    // ---------------- output register ----------------
    logic signed [AW-1:0] r_o_angle;
    logic                 r_o_zero;

    always_ff @(posedge i_clk) begin
        if (en[ST_O]) begin
            r_o_angle <= r_h_zero ? '0 : (r_h_off + r_h_val);
            r_o_zero  <= r_h_zero;
        end
    end

    assign o_rsp.valid       = r_vld[ST_O];
    assign o_rsp.angle_q8    = r_o_angle;
    assign o_rsp.zero_vector = r_o_zero;

    // ---------------- assertions ----------------
    a_zero_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.zero_vector |-> (o_rsp.angle_q8 == '0))
        else $error("zero vector transaction with nonzero angle");

    // the west octant can truncate to exactly -180
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.angle_q8 <= HALF_TURN) && (o_rsp.angle_q8 >= -HALF_TURN))
        else $error("angle beyond a half turn");

    a_full_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> o_rsp.valid && !o_rsp.ready)
        else $error("input back-pressure without output stall");

    a_div_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_H-1] && !r_g_side[QB-1].dz |-> (r_g_rem[QB-1] < r_g_den[QB-1]))
        else $error("divider remainder not below denominator");

    a_quo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_H-1] && !r_g_side[QB-1].dz |-> (r_g_quo[QB-1] <= QMAX))
        else $error("quotient exceeds a full sector");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for approx_vector_angle_degrees: random streams, APB setup, prediction.
`timescale 1ns / 1ps

module tb;
    import avad_pkg::*;

    localparam int COORD_W      = COORD_WIDTH_DEF;
    localparam int FRAC_W       = ANGLE_FRAC_BITS_DEF;
    localparam int ANGLE_W      = FRAC_W + ANGLE_INT_BITS;
    localparam int PIPE_LATENCY = 14 + FRAC_W;
    localparam longint Q_ONE    = longint'(1) << FRAC_W;
    localparam longint SCALE45  = longint'(RATIO_DEG) << FRAC_W;

    typedef struct {
        logic                      mode;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } vec_req_t;

    typedef struct {
        logic signed [ANGLE_W-1:0] angle;
        logic                      zero;
    } angle_rsp_t;

    logic i_clk;
    logic i_rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_ADDR_WIDTH-1:0] paddr;
    logic [APB_DATA_WIDTH-1:0] pwdata;
    logic [APB_DATA_WIDTH-1:0] prdata;
    logic                      pready;

    avad_in_if  #(.COORD_WIDTH(COORD_W))    req_ch();
    avad_out_if #(.ANGLE_FRAC_BITS(FRAC_W)) rsp_ch();

    approx_vector_angle_degrees #(
        .COORD_WIDTH    (COORD_W),
        .ANGLE_FRAC_BITS(FRAC_W)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    vec_req_t         pending_vecs[$];
    angle_rsp_t       expected_angles[$];
    logic [TOL_WIDTH-1:0] zero_tol;
    bit               idle_on;
    int               errors;

    // ---------------- angle predictor ----------------

    function automatic longint unsigned mag(input longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // trunc(45 * 2^F * num / den) toward zero, numerator clamped to the denominator
    function automatic longint scaled45(input longint num, input longint den);
        longint unsigned n;
        longint unsigned d;
        longint unsigned q;
        n = mag(num);
        d = mag(den);
        if (d == 0)
            return 0;
        if (n > d)
            n = d;
        q = (n * longint'(SCALE45)) / d;
        return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint quad_angle(input longint x, input longint y);
        longint yx;
        if (y >= -x) begin
            if (y <= x)
                return scaled45(y, x);
            return DEG_90 * Q_ONE - scaled45(x, y);
        end
        if (y <= x)
            return -DEG_90 * Q_ONE - scaled45(x, y);
        yx = scaled45(y, x);
        // negative x axis lands on +180
        return (yx <= 0) ? DEG_180 * Q_ONE + yx : -DEG_180 * Q_ONE + yx;
    endfunction

    function automatic void oct_corner(input t_sec k, output longint cx, output longint cy);
        case (k)
            OCT_E:   begin cx = UNIT_Q15;        cy = 0;               end
            OCT_NE:  begin cx = HALF_SQRT2_Q15;  cy = HALF_SQRT2_Q15;  end
            OCT_N:   begin cx = 0;               cy = UNIT_Q15;        end
            OCT_NW:  begin cx = -HALF_SQRT2_Q15; cy = HALF_SQRT2_Q15;  end
            OCT_W:   begin cx = -UNIT_Q15;       cy = 0;               end
            OCT_SW:  begin cx = -HALF_SQRT2_Q15; cy = -HALF_SQRT2_Q15; end
            OCT_S:   begin cx = 0;               cy = -UNIT_Q15;       end
            default: begin cx = HALF_SQRT2_Q15;  cy = -HALF_SQRT2_Q15; end
        endcase
    endfunction

    function automatic longint oct_angle(input longint x, input longint y);
        t_sec   s;
        longint ax, ay, bx, by, base;
        if (y >= 0) begin
            if (x >= 0)
                s = (y <= x) ? OCT_E : OCT_NE;
            else
                s = (y > -x) ? OCT_N : OCT_NW;
        end else begin
            if (x < 0)
                s = (y >= x) ? OCT_W : OCT_SW;
            else
                s = (-y > x) ? OCT_S : OCT_SE;
        end
        oct_corner(s, ax, ay);
        oct_corner(t_sec'(s + 1'b1), bx, by);
        base = (s < OCT_W) ? longint'(s) * DEG_45 : (longint'(s) - 8) * DEG_45;
        return base * Q_ONE + scaled45(x * ay - y * ax, x * (ay - by) - y * (ax - bx));
    endfunction

    function automatic angle_rsp_t predict_angle(input vec_req_t r,
                                                 input logic [TOL_WIDTH-1:0] tol);
        angle_rsp_t res;
        longint     x;
        longint     y;
        x = r.x;
        y = r.y;
        res.zero  = 1'b0;
        res.angle = '0;
        if (mag(x) <= tol && mag(y) <= tol)
            res.zero = 1'b1;
        else if (r.mode == MODE_FOUR)
            res.angle = ANGLE_W'(quad_angle(x, y));
        else
            res.angle = ANGLE_W'(oct_angle(x, y));
        return res;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic logic signed [COORD_W-1:0] pick_edge();
        case ($urandom_range(0, 5))
            0:       return COORD_W'(-(2 ** (COORD_W - 1)));
            1:       return COORD_W'(-(2 ** (COORD_W - 1)) + 1);
            2:       return COORD_W'(-1);
            3:       return '0;
            4:       return COORD_W'(1);
            default: return COORD_W'(2 ** (COORD_W - 1) - 1);
        endcase
    endfunction

    function automatic vec_req_t random_vec();
        vec_req_t r;
        int       d;
        r.mode = ($urandom_range(0, 1) == 0) ? MODE_FOUR : MODE_EIGHT;
        r.x    = COORD_W'($urandom);
        r.y    = COORD_W'($urandom);
        d      = int'($urandom_range(0, 6)) - 3;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: ;                                        // full range
            4, 5: begin                                          // near the tolerance
                r.x = COORD_W'(int'($urandom_range(0, 600)) - 300);
                r.y = COORD_W'(int'($urandom_range(0, 600)) - 300);
            end
            6: begin                                             // on or beside an axis
                if ($urandom_range(0, 1)) r.x = COORD_W'(d);
                else                      r.y = COORD_W'(d);
            end
            7, 8: begin                                          // on or beside a diagonal
                if ($urandom_range(0, 1)) r.y = r.x + COORD_W'(d);
                else                      r.y = -r.x + COORD_W'(d);
            end
            default: begin
                r.x = pick_edge();
                if ($urandom_range(0, 1)) r.y = pick_edge();
            end
        endcase
        return r;
    endfunction

    task automatic push_vec(input logic m, input int x, input int y);
        vec_req_t r;
        r.mode = m;
        r.x    = COORD_W'(x);
        r.y    = COORD_W'(y);
        pending_vecs.push_back(r);
    endtask

    // ---------------- APB ----------------

    task automatic apb_access(input logic wr, input logic [APB_DATA_WIDTH-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {REG_ZERO_TOL, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (!wr && prdata !== APB_DATA_WIDTH'(zero_tol)) begin
            $display("%0t: zero_tolerance readback expected %0d actual %0d",
                     $time, zero_tol, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_tolerance(input logic [TOL_WIDTH-1:0] tol);
        apb_access(1'b1, APB_DATA_WIDTH'(tol));
        zero_tol = tol;
        apb_access(1'b0, '0);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_vecs.size() != 0 || req_ch.valid || expected_angles.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [TOL_WIDTH-1:0] tol, input int count,
                             input bit idling);
        set_tolerance(tol);
        @(negedge i_clk);
        idle_on = idling;
        repeat (count)
            pending_vecs.push_back(random_vec());
        wait_drained();
    endtask

    // ---------------- clock, reset, sequence ----------------

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        req_ch.valid  = 1'b0;
        req_ch.mode   = MODE_FOUR;
        req_ch.x_coord = '0;
        req_ch.y_coord = '0;
        rsp_ch.ready  = 1'b0;
        zero_tol      = '0;
        idle_on       = 1'b1;
        errors        = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        apb_access(1'b0, '0);           // reset value
        set_tolerance('0);
        @(negedge i_clk);
        for (int m = 0; m < 2; m++) begin
            push_vec(m[0], 0, 0);
            push_vec(m[0], 32767, 0);
            push_vec(m[0], -32768, 0);
            push_vec(m[0], 0, 32767);
            push_vec(m[0], 0, -32768);
            push_vec(m[0], 100, 100);
            push_vec(m[0], -100, 100);
            push_vec(m[0], -100, -100);
            push_vec(m[0], 100, -100);
            push_vec(m[0], -32768, -32768);
            push_vec(m[0], 32767, -32768);
            push_vec(m[0], -32768, -1);
        end
        wait_drained();

        run_phase(16'hFFFF, 40, 1'b1);
        run_phase(16'd1, 200, 1'b1);
        run_phase(16'h7FFF, 40, 1'b1);
        run_phase(TOL_WIDTH'($urandom), 150, 1'b1);
        run_phase(16'd100, 150, 1'b1);
        run_phase(16'd0, 250, 1'b0);

        repeat (2 * PIPE_LATENCY) @(posedge i_clk);
        if (errors == 0 && expected_angles.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // ---------------- request driver ----------------

    vec_req_t cur_vec;
    int       src_gap;
    int       src_quiet;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            src_gap   = 0;
            src_quiet = 0;
        end else if (!(req_ch.valid && !req_ch.ready)) begin
            if (req_ch.valid)
                expected_angles.push_back(predict_angle(cur_vec, zero_tol));
            if (src_quiet > 0)
                src_quiet--;
            if (src_gap > 0) begin
                src_gap--;
                req_ch.valid <= 1'b0;
            end else if (pending_vecs.size() != 0) begin
                if (idle_on && src_quiet == 0 && $urandom_range(0, 99) < 20) begin
                    src_gap   = $urandom_range(0, 13);
                    src_quiet = $urandom_range(0, 60);
                    req_ch.valid <= 1'b0;
                end else begin
                    cur_vec = pending_vecs.pop_front();
                    req_ch.valid   <= 1'b1;
                    req_ch.mode    <= cur_vec.mode;
                    req_ch.x_coord <= cur_vec.x;
                    req_ch.y_coord <= cur_vec.y;
                end
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // ---------------- result monitor ----------------

    angle_rsp_t want;
    int         snk_gap;
    int         snk_quiet;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            snk_gap   = 0;
            snk_quiet = 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_angles.size() == 0) begin
                    $display("%0t: unexpected result angle %0d zero %0d", $time,
                             rsp_ch.angle_q8, rsp_ch.zero_vector);
                    errors++;
                end else begin
                    want = expected_angles.pop_front();
                    if (rsp_ch.angle_q8 !== want.angle) begin
                        $display("%0t: angle_q8 expected %0d actual %0d", $time,
                                 want.angle, rsp_ch.angle_q8);
                        errors++;
                    end
                    if (rsp_ch.zero_vector !== want.zero) begin
                        $display("%0t: zero_vector expected %0d actual %0d", $time,
                                 want.zero, rsp_ch.zero_vector);
                        errors++;
                    end
                end
            end
            if (snk_quiet > 0)
                snk_quiet--;
            if (snk_gap > 0) begin
                snk_gap--;
                rsp_ch.ready <= 1'b0;
            end else if (idle_on && snk_quiet == 0 && $urandom_range(0, 99) < 20) begin
                snk_gap   = $urandom_range(0, 13);
                snk_quiet = $urandom_range(0, 60);
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

endmodule
